// ----- rtl/symbol_string_token_scanner_core_assert.svh -----
// ----------------------------------------------------------------------------
// symbol_string_token_scanner_core_assert.svh
// assertion macros shared by the token scanner modules
// ----------------------------------------------------------------------------
`ifndef SYMBOL_STRING_TOKEN_SCANNER_CORE_ASSERT_SVH
`define SYMBOL_STRING_TOKEN_SCANNER_CORE_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define SSTSCAN_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, ignored while in reset
`define SSTSCAN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sstscan_pkg.sv -----
// ----------------------------------------------------------------------------
// sstscan_pkg
// shared types and constants of the symbol/string token scanner
// ----------------------------------------------------------------------------
`default_nettype none

package sstscan_pkg;

    // field widths of the token record
    localparam int KIND_W = 3;
    localparam int FIELD_W = 16;

    // pair queue depth between front and back, power of two
    localparam int Q_DEPTH = 4;

    // token kinds
    localparam logic [KIND_W-1:0] KIND_END     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CALL    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LITERAL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SYMBOL  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

    // one token record
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic               last;
    } t_token;

    // all records caused by one source byte (one or two)
    typedef struct packed {
        t_token first;
        t_token second;
        logic   two;
    } t_pair;

endpackage

`default_nettype wire

// ----- rtl/sstscan_if.sv -----
// ----------------------------------------------------------------------------
// sstscan_if
// valid/ready channels for source bytes and token records
// ----------------------------------------------------------------------------
`default_nettype none

interface sstscan_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface sstscan_token_if;
    import sstscan_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] token_line;
    logic               last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output token_line, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input token_line, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sstscan_front.sv -----
// ----------------------------------------------------------------------------
// sstscan_front
// takes one source byte per cycle while the queue is not full, runs the
// scanner state and builds the token records that the byte finishes
// ----------------------------------------------------------------------------
`default_nettype none

module sstscan_front #(
    parameter int POSITION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    sstscan_byte_if.sink        i_src,
    input  logic                i_full,
    output logic                o_push,
    output sstscan_pkg::t_pair  o_pair
);
    import sstscan_pkg::*;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;

    localparam logic [FIELD_W-1:0] SAT_MAX = '1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_SYMBOL,
        MODE_LITERAL
    } t_mode;

    // number prefix recognizer: sign, digit, inf, nan
    typedef enum logic [2:0] {
        PFX_START,
        PFX_SIGN,
        PFX_I,
        PFX_IN,
        PFX_N,
        PFX_NA,
        PFX_NUMBER,
        PFX_SYMBOL
    } t_pfx;

    function automatic logic is_sym(input logic [7:0] c);
        logic alpha;
        logic digit;
        alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        digit = (c >= 8'h30 && c <= 8'h39);
        return alpha || digit || c == CH_MINUS || c == CH_QUEST || c == CH_LT ||
               c == CH_EQ || c == CH_UNDER || c == CH_GT || c == CH_PLUS ||
               c == CH_BANG || c == CH_STAR || c == CH_BSLASH || c == CH_SLASH;
    endfunction

    function automatic t_pfx pfx_next(input t_pfx s, input logic [7:0] c);
        logic [7:0] lc;
        logic       digit;
        t_pfx       first;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        digit = (c >= 8'h30 && c <= 8'h39);
        // first character after an optional sign
        if (digit) begin
            first = PFX_NUMBER;
        end else if (lc == CH_LOW_I) begin
            first = PFX_I;
        end else if (lc == CH_LOW_N) begin
            first = PFX_N;
        end else begin
            first = PFX_SYMBOL;
        end
        unique case (s)
            PFX_START:  return (c == CH_PLUS || c == CH_MINUS) ? PFX_SIGN : first;
            PFX_SIGN:   return first;
            PFX_I:      return (lc == CH_LOW_N) ? PFX_IN : PFX_SYMBOL;
            PFX_IN:     return (lc == CH_LOW_F) ? PFX_NUMBER : PFX_SYMBOL;
            PFX_N:      return (lc == CH_LOW_A) ? PFX_NA : PFX_SYMBOL;
            PFX_NA:     return (lc == CH_LOW_N) ? PFX_NUMBER : PFX_SYMBOL;
            PFX_NUMBER: return PFX_NUMBER;
            PFX_SYMBOL: return PFX_SYMBOL;
            default:    return PFX_SYMBOL;
        endcase
    endfunction

    function automatic t_token mk_tok(input logic [KIND_W-1:0] k,
                                      input logic [FIELD_W-1:0] s,
                                      input logic [FIELD_W-1:0] l,
                                      input logic [FIELD_W-1:0] ln);
        t_token t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.line   = ln;
        t.last   = 1'b0;
        return t;
    endfunction

    // scanner state
    t_mode                    r_mode, n_mode;
    logic                     r_dbl, n_dbl;
    logic                     r_esc, n_esc;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_origin, n_origin;
    logic [FIELD_W-1:0]       r_line, n_line;
    t_pfx                     r_pfx, n_pfx;
    logic [FIELD_W-1:0]       r_run, n_run;

    logic                          w_acc;
    logic [7:0]                    w_b;
    logic [POSITION_BITS+15:0]     w_pos_ext;
    logic [POSITION_BITS+15:0]     w_org_ext;
    logic [FIELD_W-1:0]            w_start, w_origin;
    logic [FIELD_W-1:0]            w_line_inc, w_run_inc;
    logic [7:0]                    w_quote;
    logic                          w_sym;
    logic                          w_idle_run;
    logic                          w_emit_i;
    t_token                        w_rec0, w_rec1, w_rec_i;
    logic [1:0]                    w_cnt;

    assign i_src.ready = !i_full;
    assign w_acc = i_src.valid && !i_full;
    assign w_b = i_src.source_byte;

    // positions cut or zero-extended to the record width
    assign w_pos_ext = {16'd0, r_pos};
    assign w_org_ext = {16'd0, r_origin};
    assign w_start = w_pos_ext[FIELD_W-1:0];
    assign w_origin = w_org_ext[FIELD_W-1:0];

    assign w_line_inc = (r_line != SAT_MAX) ? r_line + 16'd1 : r_line;
    assign w_run_inc = (r_run != SAT_MAX) ? r_run + 16'd1 : r_run;
    assign w_quote = r_dbl ? CH_DQUOTE : CH_SQUOTE;
    assign w_sym = is_sym(w_b);

    // next state and records for the byte on the input
    always_comb begin
        n_mode = r_mode;
        n_dbl = r_dbl;
        n_esc = r_esc;
        n_pos = r_pos + POSITION_BITS'(1);
        n_origin = r_origin;
        n_line = r_line;
        n_pfx = r_pfx;
        n_run = r_run;
        w_rec0 = '0;
        w_rec1 = '0;
        w_rec_i = '0;
        w_emit_i = 1'b0;
        w_cnt = 2'd0;
        w_idle_run = 1'b1;

        // open token
        unique case (r_mode)
            MODE_SYMBOL: begin
                if (w_sym) begin
                    n_pfx = pfx_next(r_pfx, w_b);
                    n_run = w_run_inc;
                    w_idle_run = 1'b0;
                end else begin
                    w_rec0 = mk_tok((r_pfx == PFX_NUMBER) ? KIND_NUMBER : KIND_SYMBOL,
                                    w_origin, r_run, r_line);
                    w_cnt = 2'd1;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_LITERAL: begin
                if (w_b == CH_NUL) begin
                    // unterminated literal ends before the terminator
                    w_rec0 = mk_tok(KIND_LITERAL, w_origin, r_run, r_line);
                    w_cnt = 2'd1;
                    n_mode = MODE_IDLE;
                end else begin
                    w_idle_run = 1'b0;
                    n_run = w_run_inc;
                    if (r_esc && w_b == w_quote) begin
                        n_esc = 1'b0;
                    end else if (w_b == w_quote) begin
                        w_rec0 = mk_tok(KIND_LITERAL, w_origin, w_run_inc, r_line);
                        w_cnt = 2'd1;
                        n_mode = MODE_IDLE;
                        n_esc = 1'b0;
                    end else begin
                        if (w_b == CH_NL) begin
                            n_line = w_line_inc;
                        end
                        n_esc = (w_b == CH_BSLASH);
                    end
                end
            end
            MODE_IDLE: ;
            default: ;
        endcase

        // byte handled as between tokens
        if (w_idle_run) begin
            priority if (w_b == CH_NUL) begin
                w_rec_i = mk_tok(KIND_END, w_start, '0, r_line);
                w_emit_i = 1'b1;
                n_pos = '0;
                n_origin = '0;
                n_line = 16'd1;
                n_mode = MODE_IDLE;
                n_esc = 1'b0;
                n_dbl = 1'b0;
                n_pfx = PFX_START;
                n_run = '0;
            end else if (w_b == CH_NL) begin
                n_line = w_line_inc;
            end else if (w_b == CH_SPACE || w_b == CH_TAB || w_b == CH_CR) begin
                n_line = r_line;
            end else if (w_b == CH_COLON) begin
                w_rec_i = mk_tok(KIND_CALL, w_start, 16'd1, r_line);
                w_emit_i = 1'b1;
            end else if (w_b == CH_DQUOTE || w_b == CH_SQUOTE) begin
                n_mode = MODE_LITERAL;
                n_dbl = (w_b == CH_DQUOTE);
                n_esc = 1'b0;
                n_origin = r_pos;
                n_run = 16'd1;
            end else if (w_sym) begin
                n_mode = MODE_SYMBOL;
                n_origin = r_pos;
                n_run = 16'd1;
                n_pfx = pfx_next(PFX_START, w_b);
            end else begin
                w_rec_i = mk_tok(KIND_ERROR, w_start, 16'd1, r_line);
                w_emit_i = 1'b1;
            end

            if (w_emit_i) begin
                if (w_cnt == 2'd0) begin
                    w_rec0 = w_rec_i;
                    w_cnt = 2'd1;
                end else begin
                    w_rec1 = w_rec_i;
                    w_cnt = 2'd2;
                end
            end
        end

        // mark the final record of this byte
        if (w_cnt == 2'd2) begin
            w_rec1.last = 1'b1;
        end else begin
            w_rec0.last = 1'b1;
        end
    end

    assign o_push = w_acc && (w_cnt != 2'd0);
    assign o_pair = '{first: w_rec0, second: w_rec1, two: (w_cnt == 2'd2)};

    // state update on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_dbl <= 1'b0;
            r_esc <= 1'b0;
            r_pos <= '0;
            r_origin <= '0;
            r_line <= 16'd1;
            r_pfx <= PFX_START;
            r_run <= '0;
        end else if (w_acc) begin
            r_mode <= n_mode;
            r_dbl <= n_dbl;
            r_esc <= n_esc;
            r_pos <= n_pos;
            r_origin <= n_origin;
            r_line <= n_line;
            r_pfx <= n_pfx;
            r_run <= n_run;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sstscan_queue.sv -----
// ----------------------------------------------------------------------------
// sstscan_queue
// short first-word-fall-through queue of record pairs between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "symbol_string_token_scanner_core_assert.svh"

module sstscan_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sstscan_pkg::t_pair  i_data,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_empty,
    output sstscan_pkg::t_pair  o_data
);
    import sstscan_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_pair             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push, w_pop;

    assign o_full = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    `SSTSCAN_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `SSTSCAN_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(Q_DEPTH), "count overflow")
    `SSTSCAN_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, w_pop && !w_push, r_cnt == $past(r_cnt) - CNT_W'(1), "pop did not drain")

endmodule

`default_nettype wire

// ----- rtl/sstscan_back.sv -----
// ----------------------------------------------------------------------------
// sstscan_back
// splits record pairs into single token items behind an output register
// ----------------------------------------------------------------------------
`default_nettype none
`include "symbol_string_token_scanner_core_assert.svh"

module sstscan_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  sstscan_pkg::t_pair  i_pair,
    output logic                o_pop,
    sstscan_token_if.source     o_tok
);
    import sstscan_pkg::*;

    t_token r_out;
    logic   r_out_vld;
    t_token r_sec;
    logic   r_sec_vld;
    logic   w_free;

    // output slot can take a new record this cycle
    assign w_free = !r_out_vld || o_tok.ready;
    assign o_pop = w_free && !r_sec_vld && !i_empty;

    assign o_tok.valid = r_out_vld;
    assign o_tok.token_kind = r_out.kind;
    assign o_tok.token_start = r_out.start;
    assign o_tok.token_length = r_out.length;
    assign o_tok.token_line = r_out.line;
    assign o_tok.last_of_run = r_out.last;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_sec_vld <= 1'b0;
        end else if (w_free) begin
            if (r_sec_vld) begin
                r_out_vld <= 1'b1;
                r_sec_vld <= 1'b0;
            end else if (!i_empty) begin
                r_out_vld <= 1'b1;
                r_sec_vld <= i_pair.two;
            end else begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // record payload
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_sec_vld) begin
                r_out <= r_sec;
            end else if (!i_empty) begin
                r_out <= i_pair.first;
                r_sec <= i_pair.second;
            end
        end
    end

    `SSTSCAN_ASSERT_NOW(a_sec_needs_out, i_clk, i_rst_n, r_sec_vld, r_out_vld, "second record without first")
    `SSTSCAN_ASSERT_NOW(a_first_not_last, i_clk, i_rst_n, r_sec_vld, !r_out.last, "first of pair marked last")
    `SSTSCAN_ASSERT_NOW(a_open_run, i_clk, i_rst_n, r_out_vld && !r_out.last, r_sec_vld, "open run with no second record")

endmodule

`default_nettype wire

// ----- rtl/symbol_string_token_scanner_core.sv -----
// Path: a byte's records go through the pair queue into the back end's output register.
// Throughput: one source byte per cycle while the queue is not full; the back end sends one
// token item per cycle while the output is ready, the four-entry pair queue absorbing bytes
// that finish two tokens. Input ready drops only when the pair queue is full.
// Reset: synchronous, active low; scanner idle, position 0, line 1, queue and output empty.
// ----------------------------------------------------------------------------
// symbol_string_token_scanner_core
// byte-serial lexical scanner: front scanner, pair queue and output back end
// ----------------------------------------------------------------------------
`default_nettype none

module symbol_string_token_scanner_core #(
    parameter int POSITION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sstscan_byte_if.sink     i_src,
    sstscan_token_if.source  o_tok
);
    import sstscan_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_full;
    logic  w_empty;
    t_pair w_push_pair;
    t_pair w_head_pair;

    // scanner front end
    sstscan_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (i_src),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_pair  (w_push_pair)
    );

    // pair queue
    sstscan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_pair),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_head_pair)
    );

    // output back end
    sstscan_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_pair  (w_head_pair),
        .o_pop   (w_pop),
        .o_tok   (o_tok)
    );

endmodule

`default_nettype wire
